// File: design/bole_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bole_pkg
// Shared types and constants for the bounded ordered list engine.
// -----------------------------------------------------------------------------
package bole_pkg;

   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;
   localparam int CMD_W    = 3;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Internal count must hold CAPACITY itself.
   localparam int CNT_W = $clog2(CAPACITY + 1);
   // Width used to compare cell positions against an index or the count.
   localparam int SEL_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND   = 3'd0,
      CMD_PREPEND  = 3'd1,
      CMD_REMOVE   = 3'd2,
      CMD_CONTAINS = 3'd3,
      CMD_GET      = 3'd4,
      CMD_FIRST    = 3'd5,
      CMD_LAST     = 3'd6,
      CMD_LENGTH   = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Controls broadcast to every cell of the chain.
   typedef struct packed {
      logic              load_tail;   // append into the first empty cell
      logic              push_front;  // shift toward the tail, head takes value
      logic              pull_match;  // close the gap at the first match
      logic [DATA_W-1:0] value;       // operand of the current beat
   } cell_ctl_type;

endpackage

// File: design/bole_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bole_req_if / bole_rsp_if
// Valid/ready channels carrying command beats and result beats.
// -----------------------------------------------------------------------------
interface bole_req_if;
   import bole_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic signed [DATA_W-1:0]  item_value;
   logic [INDEX_W-1:0]        index;

   modport source (output valid, output cmd, output item_value, output index,
                   input ready);
   modport sink   (input valid, input cmd, input item_value, input index,
                   output ready);
endinterface

interface bole_rsp_if;
   import bole_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [DATA_W-1:0]  value_out;
   logic                      found;
   logic [STATUS_W-1:0]       status;
   logic [COUNT_W-1:0]        count;

   modport source (output valid, output value_out, output found, output status,
                   output count, input ready);
   modport sink   (input valid, input value_out, input found, input status,
                   input count, output ready);
endinterface

// File: design/bole_cell.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bole_cell
// One list position: holds an entry and its valid bit, compares it against
// the operand and moves data to or from its neighbors.
// -----------------------------------------------------------------------------
module bole_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  bole_pkg::cell_ctl_type         ctl,
   input  logic [bole_pkg::DATA_W-1:0]    left_value,
   input  logic                           left_valid,
   input  logic [bole_pkg::DATA_W-1:0]    right_value,
   input  logic                           right_valid,
   input  logic                           hit_in,
   output logic                           hit_out,
   output logic [bole_pkg::DATA_W-1:0]    value,
   output logic                           valid
);
   import bole_pkg::*;

   logic [DATA_W-1:0] value_ff, value_in;
   logic              valid_ff, valid_in;
   logic              match;

   assign match   = valid_ff && (value_ff == ctl.value);
   assign hit_out = hit_in || match;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctl.push_front) begin
         value_in = left_value;
         valid_in = left_valid;
      end else if (ctl.load_tail) begin
         // The first empty cell is the one whose left neighbor is occupied.
         if (!valid_ff && left_valid) begin
            value_in = ctl.value;
            valid_in = 1'b1;
         end
      end else if (ctl.pull_match && hit_out) begin
         value_in = right_value;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

// File: design/bounded_ordered_list_engine_core.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bounded_ordered_list_engine_core
// Ordered list of signed entries kept in a chain of cells, with append,
// prepend, remove, search and read commands.
//
//   channel  dir  beat contents
//   req_ch   in   cmd, item_value, index
//   rsp_ch   out  value_out, found, status, count
//
// One command beat is taken per clock; its result beat is registered and
// appears the cycle after acceptance. The list updates at the same edge, so
// back-to-back commands see each other's effects. A search or remove resolves
// through the OR chain across all cells within that cycle. A stalled result
// holds and blocks new commands until it is taken. Reset empties the list.
// -----------------------------------------------------------------------------
module bounded_ordered_list_engine_core (
   input  logic        clock,
   input  logic        reset,
   bole_req_if.sink    req_ch,
   bole_rsp_if.source  rsp_ch
);
   import bole_pkg::*;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   value_out_ff, value_out_in;
   logic                found_ff, found_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic                accept;
   logic                full;
   logic                rd_en;
   logic [SEL_W-1:0]    rd_sel;
   logic [DATA_W-1:0]   rd_data;
   cell_ctl_type        ctl;
   cmd_type             cmd;

   logic [DATA_W-1:0]   cell_value [CAPACITY];
   logic                cell_valid [CAPACITY];
   logic                hit        [CAPACITY+1];

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = (count_ff == CNT_W'(CAPACITY));
   assign cmd          = cmd_type'(req_ch.cmd);

   assign ctl.value      = req_ch.item_value;
   assign ctl.load_tail  = accept && (cmd == CMD_APPEND) && !full;
   assign ctl.push_front = accept && (cmd == CMD_PREPEND) && !full;
   assign ctl.pull_match = accept && (cmd == CMD_REMOVE);

   assign hit[0] = 1'b0;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_W-1:0] lv, rv;
      logic              lvld, rvld;
      if (g == 0) begin : g_head
         // The head sees the operand as its left neighbor.
         assign lv   = ctl.value;
         assign lvld = 1'b1;
      end else begin : g_body
         assign lv   = cell_value[g-1];
         assign lvld = cell_valid[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign rv   = '0;
         assign rvld = 1'b0;
      end else begin : g_inner
         assign rv   = cell_value[g+1];
         assign rvld = cell_valid[g+1];
      end
      bole_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_value  (lv),
         .left_valid  (lvld),
         .right_value (rv),
         .right_valid (rvld),
         .hit_in      (hit[g]),
         .hit_out     (hit[g+1]),
         .value       (cell_value[g]),
         .valid       (cell_valid[g])
      );
   end

   // Read port: select one cell by position.
   always_comb begin
      rd_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (rd_sel == SEL_W'(i)) begin
            rd_data = rd_data | cell_value[i];
         end
      end
   end

   always_comb begin
      count_in     = count_ff;
      found_in     = 1'b0;
      status_in    = ST_OK;
      rd_en        = 1'b0;
      rd_sel       = '0;
      case (cmd)
         CMD_APPEND, CMD_PREPEND: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_REMOVE: begin
            found_in = hit[CAPACITY];
            if (hit[CAPACITY]) begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_CONTAINS: begin
            found_in = hit[CAPACITY];
         end
         CMD_GET: begin
            rd_sel = SEL_W'(req_ch.index);
            if (SEL_W'(req_ch.index) < SEL_W'(count_ff)) begin
               rd_en = 1'b1;
            end else begin
               status_in = ST_RANGE;
            end
         end
         CMD_FIRST: begin
            if (count_ff != '0) begin
               rd_en = 1'b1;
            end else begin
               status_in = ST_RANGE;
            end
         end
         CMD_LAST: begin
            rd_sel = SEL_W'(count_ff - CNT_W'(1));
            if (count_ff != '0) begin
               rd_en = 1'b1;
            end else begin
               status_in = ST_RANGE;
            end
         end
         default: begin
         end
      endcase
      value_out_in = rd_en ? rd_data : '0;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         value_out_ff <= value_out_in;
         found_ff     <= found_in;
         status_ff    <= status_in;
      end
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.value_out = value_out_ff;
   assign rsp_ch.found     = found_ff;
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.count     = COUNT_W'(count_ff);

endmodule
